// ===== hdl/mi3_pkg.sv =====
package mi3_pkg;

  localparam int unsigned ELEM_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned THR_W          = 31;
  localparam int unsigned NUM_ELEM       = 9;
  localparam logic [THR_W-1:0] THR_RESET = 31'd1;

endpackage

// ===== hdl/mi3_cof_lane.sv =====
module mi3_cof_lane #(
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic [4:0]                   en_i,
  input  logic signed [ELEM_WIDTH-1:0] a_i,
  input  logic signed [ELEM_WIDTH-1:0] b_i,
  input  logic signed [ELEM_WIDTH-1:0] c_i,
  input  logic signed [ELEM_WIDTH-1:0] d_i,
  output logic signed [2*ELEM_WIDTH:0] cof1_o,
  output logic signed [2*ELEM_WIDTH:0] cof4_o
);

  localparam int unsigned PW = 2 * ELEM_WIDTH;
  localparam int unsigned CW = 2 * ELEM_WIDTH + 1;

  logic signed [PW-1:0] p1_q, p2_q;
  logic signed [CW-1:0] cof_q [4];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p1_q <= a_i * b_i;
      p2_q <= c_i * d_i;
    end
    if (en_i[1]) begin
      cof_q[0] <= CW'(p1_q) - CW'(p2_q);
    end
    for (int k = 1; k < 4; k++) begin
      if (en_i[k+1]) begin
        cof_q[k] <= cof_q[k-1];
      end
    end
  end

  assign cof1_o = cof_q[0];
  assign cof4_o = cof_q[3];

endmodule

// ===== hdl/mi3_det.sv =====
module mi3_det #(
  parameter int unsigned ELEM_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                           clk_i,
  input  logic [4:0]                     en_i,
  input  logic signed [ELEM_WIDTH-1:0]   row0_i [3],
  input  logic signed [2*ELEM_WIDTH:0]   cof_i  [3],
  input  logic [mi3_pkg::THR_W-1:0]      thr_i,
  output logic [3*ELEM_WIDTH-1:0]        absd_o,
  output logic                           dneg_o,
  output logic                           sing_o
);

  import mi3_pkg::*;

  localparam int unsigned E  = ELEM_WIDTH;
  localparam int unsigned DW = 3 * E + 3;
  localparam int unsigned AW = 3 * E;
  localparam int unsigned TW = THR_W + 2 * FRAC_BITS;
  localparam int unsigned KW = (AW > TW) ? AW : TW;

  logic signed [E-1:0]   row0_q0 [3];
  logic signed [E-1:0]   row0_q1 [3];
  logic signed [2*E:0]   plo_q [3];
  logic signed [2*E:0]   phi_q [3];
  logic signed [DW-1:0]  det_q, det_d;
  logic signed [DW-1:0]  det_neg;
  logic [AW-1:0]         absd_q, absd_d;
  logic                  dneg_q, sing_q, sing_d;

  // The cofactor is split into an unsigned low half and a signed high half
  // so that each partial product takes operands near element width.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      row0_q0 <= row0_i;
    end
    if (en_i[1]) begin
      row0_q1 <= row0_q0;
    end
    if (en_i[2]) begin
      for (int j = 0; j < 3; j++) begin
        plo_q[j] <= row0_q1[j] * $signed({1'b0, cof_i[j][E-1:0]});
        phi_q[j] <= row0_q1[j] * $signed(cof_i[j][2*E:E]);
      end
    end
    if (en_i[3]) begin
      det_q <= det_d;
    end
    if (en_i[4]) begin
      absd_q <= absd_d;
      dneg_q <= det_q[DW-1];
      sing_q <= sing_d;
    end
  end

  always_comb begin
    det_d = '0;
    for (int j = 0; j < 3; j++) begin
      det_d = det_d + (DW'(phi_q[j]) <<< E) + DW'(plo_q[j]);
    end
  end

  assign det_neg = -det_q;
  assign absd_d  = det_q[DW-1] ? det_neg[AW-1:0] : det_q[AW-1:0];
  assign sing_d  = (absd_d == '0) ||
                   (KW'(absd_d) < KW'({thr_i, {(2*FRAC_BITS){1'b0}}}));

  assign absd_o = absd_q;
  assign dneg_o = dneg_q;
  assign sing_o = sing_q;

endmodule

// ===== hdl/mi3_div_lane.sv =====
module mi3_div_lane #(
  parameter int unsigned ELEM_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                    clk_i,
  input  logic [ELEM_WIDTH+1:0]                   en_i,
  input  logic signed [2*ELEM_WIDTH:0]            cof_i,
  input  logic [3*ELEM_WIDTH-1:0]                 absd_i,
  input  logic                                    dneg_i,
  input  logic [ELEM_WIDTH-1:0][3*ELEM_WIDTH-1:0] absd_pipe_i,
  input  logic                                    sing_i,
  output logic [ELEM_WIDTH-1:0]                   r_o,
  output logic                                    sat_o
);

  localparam int unsigned E  = ELEM_WIDTH;
  localparam int unsigned NW = 2 * E + 2 * FRAC_BITS;
  localparam int unsigned W  = (NW > 4 * E) ? NW : 4 * E;
  localparam logic [E-1:0] MAXP = {1'b0, {(E-1){1'b1}}};
  localparam logic [E-1:0] MAXN = {1'b1, {(E-1){1'b0}}};

  logic [W-1:0]       rem_q [E];
  logic [E-1:0]       q_q   [E+1];
  logic               neg_q [E+1];
  logic               ovf_q [E+1];
  logic signed [2*E:0] cof_abs;
  logic [W-1:0]       num;
  logic [E-1:0]       r_q, r_d, q_neg;
  logic               sat_q, sat_d;

  assign cof_abs = cof_i[2*E] ? -cof_i : cof_i;
  assign num     = W'({cof_abs[2*E-1:0], {(2*FRAC_BITS){1'b0}}});

  // A quotient that needs more than element width bits is flagged at load and saturates at the output.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= num;
      q_q[0]   <= '0;
      neg_q[0] <= cof_i[2*E] ^ dneg_i;
      ovf_q[0] <= num >= (W'(absd_i) << E);
    end
  end

  for (genvar t = 0; t < E; t++) begin : g_bit
    localparam int unsigned B = E - 1 - t;
    logic [W-1:0] sub;
    logic         ge;

    assign sub = W'(absd_pipe_i[t]) << B;
    assign ge  = rem_q[t] >= sub;

    always_ff @(posedge clk_i) begin
      if (en_i[t+1]) begin
        q_q[t+1]   <= q_q[t] | (ge ? (E'(1) << B) : E'(0));
        neg_q[t+1] <= neg_q[t];
        ovf_q[t+1] <= ovf_q[t];
      end
    end

    if (t + 1 < E) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i[t+1]) begin
          rem_q[t+1] <= ge ? rem_q[t] - sub : rem_q[t];
        end
      end
    end
  end

  assign q_neg = -q_q[E];

  always_comb begin
    r_d   = neg_q[E] ? q_neg : q_q[E];
    sat_d = 1'b0;
    if (sing_i) begin
      r_d = '0;
    end else if (ovf_q[E]) begin
      r_d   = neg_q[E] ? MAXN : MAXP;
      sat_d = 1'b1;
    end else if (!neg_q[E] && q_q[E][E-1]) begin
      r_d   = MAXP;
      sat_d = 1'b1;
    end else if (neg_q[E] && q_q[E][E-1] && (|q_q[E][E-2:0])) begin
      r_d   = MAXN;
      sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[E+1]) begin
      r_q   <= r_d;
      sat_q <= sat_d;
    end
  end

  assign r_o   = r_q;
  assign sat_o = sat_q;

endmodule

// ===== hdl/matrix_inverse_3x3.sv =====
// 3x3 matrix inverse by adjugate, signed fixed point elements.
// Input: one matrix per s_axis transaction, elements m00..m22 packed row by
// row in tdata, ELEM_WIDTH bits each. Output: one m_axis transaction per
// input with r00..r22 in the same packing and tuser {saturated, singular}.
// The determinant threshold is written through cfg_we_i / cfg_wdata_i; the
// user must write it only while the block is idle, which the block itself
// does not enforce; it resets to one LSB. Throughput is one matrix per cycle
// unless the receiver stalls the output; the divider lanes retire one
// quotient bit per stage.
// Nine cofactor lanes and nine divider lanes run side by side; a merge stage
// forms the determinant and its singular test, and the saturation flags of
// the divider lanes are ORed at the output.
// Every stage holds its transaction until the next stage can take it, so a
// stalled receiver fills the pipeline bubble by bubble before s_axis_tready
// falls. Reset empties the pipeline and restores the threshold.
module matrix_inverse_3x3 #(
  parameter int unsigned ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_we_i,
  input  logic [mi3_pkg::THR_W-1:0]                  cfg_wdata_i,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up
  input  logic [((9*ELEM_WIDTH+7)/8)*8-1:0]          s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22 from bit 0 up
  output logic [((9*ELEM_WIDTH+7)/8)*8-1:0]          m_axis_tdata,
  // singular at bit 0, saturated at bit 1
  output logic [1:0]                                 m_axis_tuser
);

  import mi3_pkg::*;

  localparam int unsigned E    = ELEM_WIDTH;
  localparam int unsigned NSTG = E + 7;

  logic [THR_W-1:0]        thr_q;
  logic [NSTG-1:0]         vld_q, vld_d, rdy, in_vld, en;
  logic signed [E-1:0]     elem [NUM_ELEM];
  logic signed [E-1:0]     row0 [3];
  logic signed [2*E:0]     cof1 [NUM_ELEM];
  logic signed [2*E:0]     cof4 [NUM_ELEM];
  logic signed [2*E:0]     cof_row0 [3];
  logic [3*E-1:0]          absd;
  logic                    dneg, sing;
  logic [E-1:0][3*E-1:0]   absd_pipe_q;
  logic [E:0]              sing_pipe_q;
  logic                    sing_out_q;
  logic [E-1:0]            res [NUM_ELEM];
  logic [NUM_ELEM-1:0]     sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      vld_q <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      vld_q <= vld_d;
    end
  end

  // Each stage moves when it is empty or its successor moves.
  always_comb begin
    rdy[NSTG-1] = !vld_q[NSTG-1] || m_axis_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    in_vld[0] = s_axis_tvalid;
    for (int k = 1; k < NSTG; k++) begin
      in_vld[k] = vld_q[k-1];
    end
    en    = rdy & in_vld;
    vld_d = vld_q;
    for (int k = 0; k < NSTG; k++) begin
      if (rdy[k]) begin
        vld_d[k] = in_vld[k];
      end
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NSTG-1];

  for (genvar k = 0; k < NUM_ELEM; k++) begin : g_unpack
    assign elem[k] = s_axis_tdata[k*E +: E];
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      mi3_cof_lane #(
        .ELEM_WIDTH(E)
      ) u_cof (
        .clk_i  (clk_i),
        .en_i   (en[4:0]),
        .a_i    (elem[((i+1)%3)*3 + (j+1)%3]),
        .b_i    (elem[((i+2)%3)*3 + (j+2)%3]),
        .c_i    (elem[((i+1)%3)*3 + (j+2)%3]),
        .d_i    (elem[((i+2)%3)*3 + (j+1)%3]),
        .cof1_o (cof1[i*3+j]),
        .cof4_o (cof4[i*3+j])
      );

      // Cofactor (i, j) lands at row j, column i of the inverse.
      mi3_div_lane #(
        .ELEM_WIDTH(E),
        .FRAC_BITS (FRAC_BITS)
      ) u_div (
        .clk_i       (clk_i),
        .en_i        (en[NSTG-1:5]),
        .cof_i       (cof4[i*3+j]),
        .absd_i      (absd),
        .dneg_i      (dneg),
        .absd_pipe_i (absd_pipe_q),
        .sing_i      (sing_pipe_q[E]),
        .r_o         (res[j*3+i]),
        .sat_o       (sat[i*3+j])
      );
    end
    assign row0[i]     = elem[i];
    assign cof_row0[i] = cof1[i];
  end

  mi3_det #(
    .ELEM_WIDTH(E),
    .FRAC_BITS (FRAC_BITS)
  ) u_det (
    .clk_i  (clk_i),
    .en_i   (en[4:0]),
    .row0_i (row0),
    .cof_i  (cof_row0),
    .thr_i  (thr_q),
    .absd_o (absd),
    .dneg_o (dneg),
    .sing_o (sing)
  );

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      absd_pipe_q[0] <= absd;
      sing_pipe_q[0] <= sing;
    end
    for (int s = 1; s < E; s++) begin
      if (en[5+s]) begin
        absd_pipe_q[s] <= absd_pipe_q[s-1];
      end
    end
    for (int s = 1; s <= E; s++) begin
      if (en[5+s]) begin
        sing_pipe_q[s] <= sing_pipe_q[s-1];
      end
    end
    if (en[NSTG-1]) begin
      sing_out_q <= sing_pipe_q[E];
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    for (int k = 0; k < NUM_ELEM; k++) begin
      m_axis_tdata[k*E +: E] = res[k];
    end
  end

  assign m_axis_tuser = {|sat, sing_out_q};

`ifndef SYNTH
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1] && m_axis_tdata == '0)
    else $error("singular result carries data or saturation");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without an output stall");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en[0] |=> vld_q[0])
    else $error("accepted transaction not captured by first stage");
`endif

endmodule
